// ===== rtl/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// UV sphere package
// Shared widths, fixed-point constants and the sideband record for the
// UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int GRID_BITS      = 10;
  localparam int COUNT_BITS     = 10;
  localparam int CFG_INDEX_BITS = 2;
  localparam int FRAC_BITS      = 15;
  localparam int POS_BITS       = 16;
  localparam int TEX_BITS       = 17;
  localparam int CORNER_BITS    = 2 * GRID_BITS;
  localparam int ANGLE_BITS     = 32;
  localparam int TRIG_BITS      = 32;

  // pi in Q2.28
  localparam logic [29:0] PI_Q28 = 30'h3243F6A9;

  // reciprocals for exact floor(v / k), v < 2^30: (v * RCP) >> SH
  localparam int SH_72 = 37;
  localparam int SH_42 = 36;
  localparam int SH_20 = 35;
  localparam int SH_6  = 33;
  localparam int SH_90 = 37;
  localparam int SH_56 = 36;
  localparam int SH_30 = 35;
  localparam int SH_12 = 34;
  localparam logic [30:0] RCP_72 = 31'(((64'd1 << SH_72) + 64'd71) / 64'd72);
  localparam logic [30:0] RCP_42 = 31'(((64'd1 << SH_42) + 64'd41) / 64'd42);
  localparam logic [30:0] RCP_20 = 31'(((64'd1 << SH_20) + 64'd19) / 64'd20);
  localparam logic [30:0] RCP_6  = 31'(((64'd1 << SH_6) + 64'd5) / 64'd6);
  localparam logic [30:0] RCP_90 = 31'(((64'd1 << SH_90) + 64'd89) / 64'd90);
  localparam logic [30:0] RCP_56 = 31'(((64'd1 << SH_56) + 64'd55) / 64'd56);
  localparam logic [30:0] RCP_30 = 31'(((64'd1 << SH_30) + 64'd29) / 64'd30);
  localparam logic [30:0] RCP_12 = 31'(((64'd1 << SH_12) + 64'd11) / 64'd12);

  typedef struct packed {
    logic                   in_range;
    logic                   quad_valid;
    logic [TEX_BITS-1:0]    texture_u;
    logic [TEX_BITS-1:0]    texture_v;
    logic [CORNER_BITS-1:0] corner_tl;
    logic [CORNER_BITS-1:0] corner_tr;
    logic [CORNER_BITS-1:0] corner_bl;
    logic [CORNER_BITS-1:0] corner_br;
  } side_t;

endpackage

// ===== rtl/uvs_sincos.sv =====
// ----------------------------------------------------------------------------
// Sine/cosine pipeline
// Turn-fraction angle in, Q2.30 sine and cosine out, eleven register stages.
// ----------------------------------------------------------------------------
module uvs_sincos (
  input  logic                                    clk,
  input  logic        [uvs_pkg::ANGLE_BITS-1:0]  angle,
  output logic signed [uvs_pkg::TRIG_BITS-1:0]   sin_out,
  output logic signed [uvs_pkg::TRIG_BITS-1:0]   cos_out
);
  import uvs_pkg::*;

  localparam logic [1:0]  QUAD_0   = 2'd0;
  localparam logic [1:0]  QUAD_1   = 2'd1;
  localparam logic [1:0]  QUAD_2   = 2'd2;
  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;

  function automatic logic [61:0] mul30x31(logic [29:0] a, logic [30:0] b);
    return {32'd0, a} * {31'd0, b};
  endfunction

  // 1 - floor(p / 2^sh) in Q30
  function automatic logic [30:0] one_minus(logic [61:0] p, int sh);
    logic [61:0] sv;
    sv = p >> sh;
    return Q30_ONE - sv[30:0];
  endfunction

  logic [29:0] r_raw, r_fold, x_c, x2_c;
  logic        sw_c;
  logic [59:0] p1_r, sq_r;
  logic [1:0]  q_r  [1:10];
  logic        sw_r [1:10];
  logic [29:0] x_r  [2:9];
  logic [29:0] x2_r [3:9];
  logic [61:0] ps_r [3:10];
  logic [61:0] pc_r [3:10];
  logic [30:0] s_v, c_v, sa, ca;
  logic signed [TRIG_BITS-1:0] sx, cx, sin_nxt, cos_nxt, sin_r, cos_r;

  always_comb begin
    r_raw  = angle[29:0];
    sw_c   = r_raw > 30'h2000_0000;
    r_fold = sw_c ? 30'(Q30_ONE - {1'b0, r_raw}) : r_raw;
    x_c    = 30'((p1_r + 60'h1000_0000) >> 29);
    x2_c   = 30'((sq_r + 60'h2000_0000) >> 30);
  end

  // final stage: sine, cosine, octant swap and quadrant signs
  always_comb begin
    s_v = ps_r[10][60:30];
    c_v = Q30_ONE - {2'b00, pc_r[10][59:31]};
    sa  = sw_r[10] ? c_v : s_v;
    ca  = sw_r[10] ? s_v : c_v;
    sx  = signed'({1'b0, sa});
    cx  = signed'({1'b0, ca});
    case (q_r[10])
      QUAD_0: begin sin_nxt = sx;  cos_nxt = cx;  end
      QUAD_1: begin sin_nxt = cx;  cos_nxt = -sx; end
      QUAD_2: begin sin_nxt = -sx; cos_nxt = -cx; end
      default: begin sin_nxt = -cx; cos_nxt = sx; end
    endcase
  end

  always_ff @(posedge clk) begin
    q_r[1]  <= angle[31:30];
    sw_r[1] <= sw_c;
    for (int k = 2; k <= 10; k++) begin
      q_r[k]  <= q_r[k-1];
      sw_r[k] <= sw_r[k-1];
    end
    p1_r   <= {30'd0, r_fold} * {30'd0, PI_Q28};
    x_r[2] <= x_c;
    for (int k = 3; k <= 9; k++) x_r[k] <= x_r[k-1];
    sq_r    <= {30'd0, x_c} * {30'd0, x_c};
    x2_r[3] <= x2_c;
    for (int k = 4; k <= 9; k++) x2_r[k] <= x2_r[k-1];

    ps_r[3]  <= mul30x31(x2_c, RCP_72);
    pc_r[3]  <= mul30x31(x2_c, RCP_90);
    ps_r[4]  <= mul30x31(x2_r[3], one_minus(ps_r[3], SH_72));
    pc_r[4]  <= mul30x31(x2_r[3], one_minus(pc_r[3], SH_90));
    ps_r[5]  <= mul30x31(ps_r[4][59:30], RCP_42);
    pc_r[5]  <= mul30x31(pc_r[4][59:30], RCP_56);
    ps_r[6]  <= mul30x31(x2_r[5], one_minus(ps_r[5], SH_42));
    pc_r[6]  <= mul30x31(x2_r[5], one_minus(pc_r[5], SH_56));
    ps_r[7]  <= mul30x31(ps_r[6][59:30], RCP_20);
    pc_r[7]  <= mul30x31(pc_r[6][59:30], RCP_30);
    ps_r[8]  <= mul30x31(x2_r[7], one_minus(ps_r[7], SH_20));
    pc_r[8]  <= mul30x31(x2_r[7], one_minus(pc_r[7], SH_30));
    ps_r[9]  <= mul30x31(ps_r[8][59:30], RCP_6);
    pc_r[9]  <= mul30x31(pc_r[8][59:30], RCP_12);
    ps_r[10] <= mul30x31(x_r[9], one_minus(ps_r[9], SH_6));
    pc_r[10] <= mul30x31(x2_r[9], one_minus(pc_r[9], SH_12));

    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  assign sin_out = sin_r;
  assign cos_out = cos_r;

endmodule

// ===== rtl/uv_sphere_vertex_generator_top.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Grid point in, half-scale sphere vertex, texture coordinates and quad
// corner indices out, one request per clock while busy is low.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a grid point (row, column) is taken at a rising edge
//   with start high and busy low. A new request may follow every cycle.
//   Result channel: out_valid is high for exactly one cycle per request,
//   with all result fields valid in that cycle. Results come out in
//   request order; the receiver cannot stall, so nothing is held back.
//   A request runs from the capture register to the output register.
//   Throughput: one request per cycle while busy is low, set by the fully
//   pipelined datapath (two eleven-stage sine/cosine units in parallel).
//   Config channel: cfg_valid/cfg_ready writes stack count (index 0) or
//   slice count (index 1); other indexes change no count. Write only while
//   no request is in flight.
//   Reciprocals of the counts come from a restoring divider that runs
//   after reset and after every config write; busy and !cfg_ready are
//   high during that pass.
//   Reset (synchronous, rst_n low): counts return to 16 stacks and
//   32 slices, the pipeline empties and the reciprocal pass restarts.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic        [uvs_pkg::GRID_BITS-1:0]    in_grid_row,
  input  logic        [uvs_pkg::GRID_BITS-1:0]    in_grid_column,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [uvs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic        [uvs_pkg::COUNT_BITS-1:0]   cfg_data,
  output logic                                    out_valid,
  output logic                                    out_in_range,
  output logic signed [uvs_pkg::POS_BITS-1:0]     out_position_x,
  output logic signed [uvs_pkg::POS_BITS-1:0]     out_position_y,
  output logic signed [uvs_pkg::POS_BITS-1:0]     out_position_z,
  output logic        [uvs_pkg::TEX_BITS-1:0]     out_texture_u,
  output logic        [uvs_pkg::TEX_BITS-1:0]     out_texture_v,
  output logic                                    out_quad_valid,
  output logic        [uvs_pkg::CORNER_BITS-1:0]  out_corner_top_left,
  output logic        [uvs_pkg::CORNER_BITS-1:0]  out_corner_top_right,
  output logic        [uvs_pkg::CORNER_BITS-1:0]  out_corner_bottom_left,
  output logic        [uvs_pkg::CORNER_BITS-1:0]  out_corner_bottom_right
);
  import uvs_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_STACK_COUNT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SLICE_COUNT = 2'd1;

  // divider steps: bit 32 of 2^32 down to bit 0
  localparam logic [5:0] RCP_TOP = 6'd32;
  localparam logic [5:0] CAP_16  = 6'd16;
  localparam logic [5:0] CAP_31  = 6'd1;
  localparam logic [5:0] CAP_32  = 6'd0;

  localparam int POS_SHIFT = 61 - FRAC_BITS;
  localparam int Y_SHIFT   = 31 - FRAC_BITS;
  localparam int PIPE_LEN  = 16;

  // round half away from zero, keep the low field bits
  function automatic logic [POS_BITS-1:0] round_pos(logic signed [63:0] v, int sh);
    logic [63:0] mag;
    logic [63:0] rnd;
    mag = v[63] ? 64'(-v) : 64'(v);
    rnd = (mag + (64'd1 << (sh - 1))) >> sh;
    if (v[63]) rnd = -rnd;
    return rnd[POS_BITS-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Config registers and reciprocal pass
  // --------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] stack_count_r, slice_count_r, stk, slc;
  logic                  rcp_busy_r;
  logic [5:0]            rcp_step_r;
  logic                  cfg_accept, in_accept;

  logic [COUNT_BITS-1:0] dv       [2];
  logic [COUNT_BITS-1:0] rcp_rem_r[2];
  logic [32:0]           rcp_quo_r[2];
  logic [COUNT_BITS:0]   rem2     [2];
  logic                  ge       [2];
  logic [COUNT_BITS-1:0] rem_nxt  [2];
  logic [32:0]           quo_nxt  [2];

  // captured reciprocal terms: lane 0 stacks, lane 1 slices
  logic [16:0]           q16_r [2];   // floor(2^16 / d)
  logic [COUNT_BITS-1:0] r16_r [2];   // 2^16 mod d
  logic [32:0]           m32_r [2];   // ceil(2^32 / d)
  logic [31:0]           q31s_r;      // floor(2^31 / stacks)
  logic [COUNT_BITS-1:0] r31s_r;
  logic [31:0]           mps_r;       // ceil(2^32 / (2*stacks))
  logic [32:0]           q32l_r;      // floor(2^32 / slices)
  logic [COUNT_BITS-1:0] r32l_r;

  // zero count acts as one
  assign stk = (stack_count_r == '0) ? COUNT_BITS'(1) : stack_count_r;
  assign slc = (slice_count_r == '0) ? COUNT_BITS'(1) : slice_count_r;
  assign dv[0] = stk;
  assign dv[1] = slc;

  assign cfg_ready  = !rcp_busy_r;
  assign busy       = rcp_busy_r;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign in_accept  = start && !busy;

  // one restoring-division step per lane; the first step seeds the dividend
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem2[l]    = (rcp_step_r == RCP_TOP) ? (COUNT_BITS+1)'(1) : {rcp_rem_r[l], 1'b0};
      ge[l]      = rem2[l] >= {1'b0, dv[l]};
      rem_nxt[l] = ge[l] ? COUNT_BITS'(rem2[l] - {1'b0, dv[l]}) : rem2[l][COUNT_BITS-1:0];
      quo_nxt[l] = {rcp_quo_r[l][31:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_count_r <= COUNT_BITS'(16);
      slice_count_r <= COUNT_BITS'(32);
      rcp_busy_r    <= 1'b1;
      rcp_step_r    <= RCP_TOP;
    end else if (cfg_accept) begin
      case (cfg_index)
        REG_STACK_COUNT: stack_count_r <= cfg_data;
        REG_SLICE_COUNT: slice_count_r <= cfg_data;
        default: ;
      endcase
      rcp_busy_r <= 1'b1;
      rcp_step_r <= RCP_TOP;
    end else if (rcp_busy_r) begin
      rcp_step_r <= rcp_step_r - 6'd1;
      if (rcp_step_r == CAP_32) rcp_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rcp_busy_r) begin
      for (int l = 0; l < 2; l++) begin
        rcp_rem_r[l] <= rem_nxt[l];
        rcp_quo_r[l] <= quo_nxt[l];
        if (rcp_step_r == CAP_16) begin
          q16_r[l] <= quo_nxt[l][16:0];
          r16_r[l] <= rem_nxt[l];
        end
        if (rcp_step_r == CAP_32) m32_r[l] <= quo_nxt[l] + {32'd0, |rem_nxt[l]};
      end
      if (rcp_step_r == CAP_31) begin
        q31s_r <= quo_nxt[0][31:0];
        r31s_r <= rem_nxt[0];
        mps_r  <= quo_nxt[0][31:0] + {31'd0, |rem_nxt[0]};
      end
      if (rcp_step_r == CAP_32) begin
        q32l_r <= quo_nxt[1];
        r32l_r <= rem_nxt[1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request pipeline
  // --------------------------------------------------------------------------
  logic [PIPE_LEN-1:0] vld_r;
  logic                out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[PIPE_LEN-2:0], in_accept};
      out_valid_r <= vld_r[PIPE_LEN-1];
    end
  end

  // stage 0: capture
  logic [GRID_BITS-1:0] row0_r, col0_r;

  // stage 1: range checks and the first products
  logic                 rng1_c, qv1_c, rng1_r, qv1_r;
  logic [GRID_BITS-1:0] col1_r;
  logic [10:0]          slc1;
  logic [20:0]          a_phi_r;
  logic [19:0]          a_th_r, a_u_r, a_v_r;
  logic [31:0]          b_phi_r, b_th_r;
  logic [32:0]          b_th_c;
  logic [16:0]          b_u_r, b_v_r;
  logic [CORNER_BITS-1:0] b_tl_r;

  assign slc1   = {1'b0, slc} + 11'd1;
  assign rng1_c = ({1'b0, row0_r} <= {1'b0, stk}) && ({1'b0, col0_r} <= {1'b0, slc});
  assign qv1_c  = (row0_r < stk) && (col0_r < slc);
  assign b_th_c = {23'd0, col0_r} * q32l_r;

  // stage 2: remainder quotients through reciprocals, corner sums
  logic [20:0]          n_phi;
  logic [19:0]          n_th, n_u, n_v;
  logic [52:0]          p_phi_r, p_th_r, p_u_r, p_v_r;
  logic [31:0]          b_phi2_r, b_th2_r;
  logic [16:0]          b_u2_r, b_v2_r;
  logic                 rng2_r, qv2_r;
  logic [CORNER_BITS-1:0] tl_c, bl_c;
  logic [CORNER_BITS-1:0] c_tl_r, c_tr_r, c_bl_r, c_br_r;

  assign n_phi = a_phi_r + 21'(stk);
  assign n_th  = a_th_r + 20'(slc >> 1);
  assign n_u   = a_u_r + 20'(slc >> 1);
  assign n_v   = a_v_r + 20'(stk >> 1);
  assign tl_c  = b_tl_r + CORNER_BITS'(col1_r);
  assign bl_c  = tl_c + CORNER_BITS'(slc1);

  // stage 3: angles and texture coordinates
  logic [ANGLE_BITS-1:0] phi_r, theta_r;
  logic [16:0]           tex_u_c, tex_v_c;
  side_t                 side_c;
  side_t                 side_r [3:14];

  assign tex_u_c = b_u2_r + 17'(p_u_r[52:32]);
  assign tex_v_c = 17'h10000 - (b_v2_r + 17'(p_v_r[52:32]));

  always_comb begin
    side_c.in_range   = rng2_r;
    side_c.quad_valid = qv2_r;
    side_c.texture_u  = rng2_r ? tex_u_c : '0;
    side_c.texture_v  = rng2_r ? tex_v_c : '0;
    side_c.corner_tl  = c_tl_r;
    side_c.corner_tr  = c_tr_r;
    side_c.corner_bl  = c_bl_r;
    side_c.corner_br  = c_br_r;
  end

  // stages 4..14: sine and cosine
  logic signed [TRIG_BITS-1:0] sp, cp, st, ct;

  uvs_sincos u_phi (
    .clk     (clk),
    .angle   (phi_r),
    .sin_out (sp),
    .cos_out (cp)
  );

  uvs_sincos u_theta (
    .clk     (clk),
    .angle   (theta_r),
    .sin_out (st),
    .cos_out (ct)
  );

  // stage 15: position products
  logic signed [63:0]          px_prod_r, pz_prod_r;
  logic signed [TRIG_BITS-1:0] cp15_r;
  side_t                       side15_r;

  // stage 16: rounded, gated outputs
  logic                        out_rng_r, out_qv_r;
  logic signed [POS_BITS-1:0]  out_px_r, out_py_r, out_pz_r;
  logic [TEX_BITS-1:0]         out_u_r, out_v_r;
  logic [CORNER_BITS-1:0]      out_tl_r, out_tr_r, out_bl_r, out_br_r;

  always_ff @(posedge clk) begin
    row0_r <= in_grid_row;
    col0_r <= in_grid_column;

    rng1_r  <= rng1_c;
    qv1_r   <= qv1_c;
    col1_r  <= col0_r;
    a_phi_r <= {11'd0, row0_r} * {10'd0, r31s_r, 1'b0};
    a_th_r  <= {10'd0, col0_r} * {10'd0, r32l_r};
    a_u_r   <= {10'd0, col0_r} * {10'd0, r16_r[1]};
    a_v_r   <= {10'd0, row0_r} * {10'd0, r16_r[0]};
    b_phi_r <= {22'd0, row0_r} * q31s_r;
    b_th_r  <= b_th_c[31:0];
    b_u_r   <= {7'd0, col0_r} * q16_r[1];
    b_v_r   <= {7'd0, row0_r} * q16_r[0];
    b_tl_r  <= {10'd0, row0_r} * {9'd0, slc1};

    p_phi_r  <= {32'd0, n_phi} * {21'd0, mps_r};
    p_th_r   <= {33'd0, n_th} * {20'd0, m32_r[1]};
    p_u_r    <= {33'd0, n_u} * {20'd0, m32_r[1]};
    p_v_r    <= {33'd0, n_v} * {20'd0, m32_r[0]};
    b_phi2_r <= b_phi_r;
    b_th2_r  <= b_th_r;
    b_u2_r   <= b_u_r;
    b_v2_r   <= b_v_r;
    rng2_r   <= rng1_r;
    qv2_r    <= qv1_r;
    c_tl_r   <= qv1_r ? tl_c : '0;
    c_tr_r   <= qv1_r ? tl_c + CORNER_BITS'(1) : '0;
    c_bl_r   <= qv1_r ? bl_c : '0;
    c_br_r   <= qv1_r ? bl_c + CORNER_BITS'(1) : '0;

    phi_r     <= b_phi2_r + 32'(p_phi_r[52:32]);
    theta_r   <= b_th2_r + 32'(p_th_r[52:32]);
    side_r[3] <= side_c;
    for (int k = 4; k <= 14; k++) side_r[k] <= side_r[k-1];

    px_prod_r <= 64'(sp) * 64'(ct);
    pz_prod_r <= 64'(sp) * 64'(st);
    cp15_r    <= cp;
    side15_r  <= side_r[14];

    out_rng_r <= side15_r.in_range;
    out_qv_r  <= side15_r.quad_valid;
    out_px_r  <= side15_r.in_range ? signed'(round_pos(px_prod_r, POS_SHIFT)) : '0;
    out_py_r  <= side15_r.in_range ? signed'(round_pos(64'(cp15_r), Y_SHIFT)) : '0;
    out_pz_r  <= side15_r.in_range ? signed'(round_pos(pz_prod_r, POS_SHIFT)) : '0;
    out_u_r   <= side15_r.texture_u;
    out_v_r   <= side15_r.texture_v;
    out_tl_r  <= side15_r.corner_tl;
    out_tr_r  <= side15_r.corner_tr;
    out_bl_r  <= side15_r.corner_bl;
    out_br_r  <= side15_r.corner_br;
  end

  assign out_valid               = out_valid_r;
  assign out_in_range            = out_rng_r;
  assign out_quad_valid          = out_qv_r;
  assign out_position_x          = out_px_r;
  assign out_position_y          = out_py_r;
  assign out_position_z          = out_pz_r;
  assign out_texture_u           = out_u_r;
  assign out_texture_v           = out_v_r;
  assign out_corner_top_left     = out_tl_r;
  assign out_corner_top_right    = out_tr_r;
  assign out_corner_bottom_left  = out_bl_r;
  assign out_corner_bottom_right = out_br_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_quad_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_quad_valid |-> out_in_range)
    else $error("quad flagged outside the grid");

  a_off_grid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |->
      out_position_x == '0 && out_position_y == '0 && out_position_z == '0 &&
      out_texture_u == '0 && out_texture_v == '0)
    else $error("off-grid result carries data");

  a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_quad_valid |->
      out_corner_top_right == out_corner_top_left + CORNER_BITS'(1) &&
      out_corner_bottom_right == out_corner_bottom_left + CORNER_BITS'(1))
    else $error("corner indices out of step");

  a_cfg_recompute: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> busy && !cfg_ready)
    else $error("config write did not start the reciprocal pass");

endmodule

// ===== bench/uvs_vertex_checker.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex checker
// Watches the request, config and result channels of the vertex generator,
// predicts each result in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module uvs_vertex_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic [uvs_pkg::GRID_BITS-1:0]      in_grid_row,
  input  logic [uvs_pkg::GRID_BITS-1:0]      in_grid_column,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [uvs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [uvs_pkg::COUNT_BITS-1:0]     cfg_data,
  input  logic                               out_valid,
  input  logic                               out_in_range,
  input  logic [uvs_pkg::POS_BITS-1:0]       out_position_x,
  input  logic [uvs_pkg::POS_BITS-1:0]       out_position_y,
  input  logic [uvs_pkg::POS_BITS-1:0]       out_position_z,
  input  logic [uvs_pkg::TEX_BITS-1:0]       out_texture_u,
  input  logic [uvs_pkg::TEX_BITS-1:0]       out_texture_v,
  input  logic                               out_quad_valid,
  input  logic [uvs_pkg::CORNER_BITS-1:0]    out_corner_top_left,
  input  logic [uvs_pkg::CORNER_BITS-1:0]    out_corner_top_right,
  input  logic [uvs_pkg::CORNER_BITS-1:0]    out_corner_bottom_left,
  input  logic [uvs_pkg::CORNER_BITS-1:0]    out_corner_bottom_right,
  output int                                 mismatch_count,
  output int                                 vertices_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import uvs_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_STACKS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SLICES = 2'd1;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  typedef struct packed {
    logic                   in_range;
    logic [POS_BITS-1:0]    pos_x;
    logic [POS_BITS-1:0]    pos_y;
    logic [POS_BITS-1:0]    pos_z;
    logic [TEX_BITS-1:0]    tex_u;
    logic [TEX_BITS-1:0]    tex_v;
    logic                   quad_valid;
    logic [CORNER_BITS-1:0] tl;
    logic [CORNER_BITS-1:0] tr;
    logic [CORNER_BITS-1:0] bl;
    logic [CORNER_BITS-1:0] br;
  } vertex_t;

  vertex_t                 expected_vertices[$];
  logic [COUNT_BITS-1:0]   stack_reg;
  logic [COUNT_BITS-1:0]   slice_reg;

  function automatic longint unsigned horner(longint unsigned x2, longint unsigned t,
                                             longint unsigned k);
    return Q30_ONE - ((x2 * t) >> 30) / k;
  endfunction

  // sine/cosine of an angle given as a 32-bit fraction of a turn, Q2.30
  function automatic void turn_sin_cos(input logic [31:0] a, output longint sn,
                                       output longint cs);
    longint unsigned r, x, x2, t, s, c, tmp;
    logic            swap;
    r    = 64'(a[29:0]);
    swap = r > (64'd1 << 29);
    if (swap) r = Q30_ONE - r;
    x  = (r * longint'(PI_Q28) + (64'd1 << 28)) >> 29;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t = Q30_ONE - x2 / 72;
    t = horner(x2, t, 42);
    t = horner(x2, t, 20);
    t = horner(x2, t, 6);
    s = (x * t) >> 30;
    t = Q30_ONE - x2 / 90;
    t = horner(x2, t, 56);
    t = horner(x2, t, 30);
    t = horner(x2, t, 12);
    c = horner(x2, t, 2);
    if (swap) begin
      tmp = s;
      s   = c;
      c   = tmp;
    end
    case (a[31:30])
      2'd0: begin sn = s;  cs = c;  end
      2'd1: begin sn = c;  cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  // half away from zero
  function automatic logic [POS_BITS-1:0] round_fixed(longint v, int sh);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    if (v < 0) mag = -mag;
    return mag[POS_BITS-1:0];
  endfunction

  function automatic vertex_t predict_vertex(logic [GRID_BITS-1:0] row_in,
                                             logic [GRID_BITS-1:0] col_in);
    vertex_t         v;
    longint unsigned row, col, stacks, slices, tl, bl, th;
    logic [31:0]     phi, theta;
    longint          sp, cp, st, ct;
    v      = '0;
    row    = 64'(row_in);
    col    = 64'(col_in);
    stacks = (stack_reg == '0) ? 64'd1 : 64'(stack_reg);  // zero count acts as one
    slices = (slice_reg == '0) ? 64'd1 : 64'(slice_reg);
    if (row > stacks || col > slices) return v;
    phi   = 32'(((row << 32) + stacks) / (2 * stacks));
    th    = ((col << 32) + slices / 2) / slices;
    theta = th[31:0];
    turn_sin_cos(phi, sp, cp);
    turn_sin_cos(theta, st, ct);
    v.in_range = 1'b1;
    v.pos_x    = round_fixed(sp * ct, 61 - FRAC_BITS);
    v.pos_y    = round_fixed(cp, 31 - FRAC_BITS);
    v.pos_z    = round_fixed(sp * st, 61 - FRAC_BITS);
    v.tex_u    = TEX_BITS'((col * 65536 + slices / 2) / slices);
    v.tex_v    = TEX_BITS'(65536 - (row * 65536 + stacks / 2) / stacks);
    if (row < stacks && col < slices) begin
      tl           = row * (slices + 1) + col;
      bl           = tl + slices + 1;
      v.quad_valid = 1'b1;
      v.tl         = CORNER_BITS'(tl);
      v.tr         = CORNER_BITS'(tl + 1);
      v.bl         = CORNER_BITS'(bl);
      v.br         = CORNER_BITS'(bl + 1);
    end
    return v;
  endfunction

  assign vertices_pending = expected_vertices.size();

  always @(posedge clk) begin
    vertex_t exp_v, got_v;
    if (!rst_n) begin
      stack_reg      = COUNT_BITS'(16);
      slice_reg      = COUNT_BITS'(32);
      mismatch_count = 0;
      expected_vertices.delete();
    end else begin
      if (out_valid) begin
        got_v = '{out_in_range, out_position_x, out_position_y, out_position_z,
                  out_texture_u, out_texture_v, out_quad_valid, out_corner_top_left,
                  out_corner_top_right, out_corner_bottom_left, out_corner_bottom_right};
        if (expected_vertices.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", got_v);
        end else begin
          exp_v = expected_vertices.pop_front();
          if (got_v !== exp_v) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %p\n          actual   %p", exp_v, got_v);
          end
        end
      end
      if (start && !busy)
        expected_vertices.insert(expected_vertices.size(),
                                 predict_vertex(in_grid_row, in_grid_column));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_STACKS) stack_reg = cfg_data;
        else if (cfg_index == REG_SLICES) slice_reg = cfg_data;
      end
    end
  end

endmodule

// ===== bench/tb_uv_sphere_vertex_generator_top.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Drives grid-point requests and count writes through several sphere
// settings; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_uv_sphere_vertex_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import uvs_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_STACKS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SLICES = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE3 = 2'd3;
  localparam int PIPE_DRAIN = 40;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [GRID_BITS-1:0]      in_grid_row;
  logic [GRID_BITS-1:0]      in_grid_column;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [COUNT_BITS-1:0]     cfg_data;
  logic                      out_valid;
  logic                      out_in_range;
  logic [POS_BITS-1:0]       out_position_x;
  logic [POS_BITS-1:0]       out_position_y;
  logic [POS_BITS-1:0]       out_position_z;
  logic [TEX_BITS-1:0]       out_texture_u;
  logic [TEX_BITS-1:0]       out_texture_v;
  logic                      out_quad_valid;
  logic [CORNER_BITS-1:0]    out_corner_top_left;
  logic [CORNER_BITS-1:0]    out_corner_top_right;
  logic [CORNER_BITS-1:0]    out_corner_bottom_left;
  logic [CORNER_BITS-1:0]    out_corner_bottom_right;
  int                        mismatch_count;
  int                        vertices_pending;

  // current sphere setting, mirrored for stimulus shaping
  int unsigned stacks_now;
  int unsigned slices_now;
  bit          no_idle;

  uv_sphere_vertex_generator_top i_dut (.*);

  uvs_vertex_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Issue one request and hold it until taken; start stays high into the
  // next request unless random idle cycles follow.
  task automatic send_point(int unsigned row, int unsigned col);
    start          <= 1'b1;
    in_grid_row    <= GRID_BITS'(row);
    in_grid_column <= GRID_BITS'(col);
    @(posedge clk);
    while (busy) @(posedge clk);
    while (!no_idle && $urandom_range(99) < 22) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Writes only with the pipe empty; start is dropped first.
  task automatic write_count(logic [CFG_INDEX_BITS-1:0] idx, int unsigned val);
    start <= 1'b0;
    @(posedge clk);
    while (vertices_pending != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= COUNT_BITS'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_STACKS) stacks_now = (val == 0) ? 1 : val;
    if (idx == REG_SLICES) slices_now = (val == 0) ? 1 : val;
  endtask

  // Mostly points within the grid or just past its edge; a few from the full range.
  task automatic random_points(int n);
    int unsigned r, c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        r = $urandom_range(1023);
        c = $urandom_range(1023);
      end else begin
        r = $urandom_range((stacks_now < 1023) ? stacks_now + 1 : 1023);
        c = $urandom_range((slices_now < 1023) ? slices_now + 1 : 1023);
      end
      send_point(r, c);
    end
  endtask

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_grid_row    <= '0;
    in_grid_column <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_STACKS;
    cfg_data       <= '0;
    stacks_now     = 16;
    slices_now     = 32;
    no_idle        = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset setting, poles, seam, grid edge and beyond
    send_point(0, 0);
    send_point(16, 0);
    send_point(8, 8);
    send_point(15, 31);
    send_point(16, 32);
    send_point(17, 5);
    send_point(3, 33);
    send_point(1023, 1023);
    send_point(4, 24);
    send_point(12, 16);
    // unknown register indexes must leave the counts alone
    write_count(REG_SPARE2, 1023);
    write_count(REG_SPARE3, 5);
    send_point(15, 31);
    send_point(16, 32);
    // zero counts act as one
    write_count(REG_STACKS, 0);
    write_count(REG_SLICES, 0);
    send_point(0, 0);
    send_point(1, 1);
    send_point(0, 1);
    send_point(2, 0);
    write_count(REG_STACKS, 1023);
    write_count(REG_SLICES, 1023);
    send_point(1022, 1022);
    send_point(1023, 1023);
    send_point(511, 767);
    send_point(0, 1023);

    // random phases over several settings, extremes included
    random_points(200);
    no_idle = 1;
    random_points(150);
    no_idle = 0;
    write_count(REG_STACKS, 1);
    write_count(REG_SLICES, 1);
    random_points(100);
    write_count(REG_STACKS, 16);
    write_count(REG_SLICES, 32);
    random_points(200);
    write_count(REG_STACKS, 3);
    write_count(REG_SLICES, 1023);
    random_points(150);
    write_count(REG_STACKS, 1023);
    write_count(REG_SLICES, 7);
    random_points(150);
    for (int p = 0; p < 4; p++) begin
      write_count(REG_STACKS, $urandom_range(1023));
      write_count(REG_SLICES, $urandom_range(1023));
      random_points(100);
    end

    start <= 1'b0;
    @(posedge clk);
    while (vertices_pending != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (mismatch_count == 0 && vertices_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
